[src/ccd_pkg.sv]
// ----------------------------------------------------------------------------
// ccd_pkg
// Shared command codes, config register indices and CORDIC constants for the CCD IK solver.
// ----------------------------------------------------------------------------
package ccd_pkg;

  localparam int CordicSteps = 24;
  localparam int GuardBits   = 4;
  localparam logic [23:0] InvGainQ24 = 24'd10188014;
  localparam logic [31:0] HalfTurn    = 32'h8000_0000;
  localparam logic [31:0] QuarterTurn = 32'h4000_0000;

  localparam logic [1:0] CMD_CLEAR  = 2'd0;
  localparam logic [1:0] CMD_APPEND = 2'd1;
  localparam logic [1:0] CMD_SOLVE  = 2'd2;

  localparam logic REG_TOLERANCE  = 1'b0;
  localparam logic REG_MAX_PASSES = 1'b1;

  // arctan(2^-k) as a binary angle, full turn = 2^32
  function automatic logic [31:0] atan_at(input logic [4:0] k);
    logic [31:0] a;
    case (k)
      5'd0:  a = 32'h20000000;
      5'd1:  a = 32'h12E4051E;
      5'd2:  a = 32'h09FB385B;
      5'd3:  a = 32'h051111D4;
      5'd4:  a = 32'h028B0D43;
      5'd5:  a = 32'h0145D7E1;
      5'd6:  a = 32'h00A2F61E;
      5'd7:  a = 32'h00517C55;
      5'd8:  a = 32'h0028BE53;
      5'd9:  a = 32'h00145F2F;
      5'd10: a = 32'h000A2F98;
      5'd11: a = 32'h000517CC;
      5'd12: a = 32'h00028BE6;
      5'd13: a = 32'h000145F3;
      5'd14: a = 32'h0000A2FA;
      5'd15: a = 32'h0000517D;
      5'd16: a = 32'h000028BE;
      5'd17: a = 32'h0000145F;
      5'd18: a = 32'h00000A30;
      5'd19: a = 32'h00000518;
      5'd20: a = 32'h0000028C;
      5'd21: a = 32'h00000146;
      5'd22: a = 32'h000000A3;
      5'd23: a = 32'h00000051;
      default: a = 32'h0;
    endcase
    return a;
  endfunction

endpackage

[src/ccd_chain_mem.sv]
// ----------------------------------------------------------------------------
// ccd_chain_mem
// Chain point store: one write port, one registered read port.
// ----------------------------------------------------------------------------
module ccd_chain_mem #(
  parameter int Depth = 16,
  parameter int Width = 48
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_o <= mem[raddr_i];
  end

endmodule

[src/ccd_cordic.sv]
// ----------------------------------------------------------------------------
// ccd_cordic
// Iterative CORDIC, one micro-rotation per cycle, vectoring or rotation mode.
// ----------------------------------------------------------------------------
module ccd_cordic #(
  parameter int CoordBits = 24
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start_i,
  input  logic                        vec_i,
  input  logic signed [CoordBits:0]   x_i,
  input  logic signed [CoordBits:0]   y_i,
  input  logic [31:0]                 ang_i,
  output logic                        done_o,
  output logic signed [CoordBits+7:0] x_o,
  output logic signed [CoordBits+7:0] y_o,
  output logic [31:0]                 ang_o
);
  import ccd_pkg::*;

  localparam int CW = CoordBits + 8;

  logic signed [CW-1:0] x_q, x_d, y_q, y_d, xs, ys, xe, ye;
  logic signed [33:0]   z_q, z_d;
  logic [4:0]           k_q, k_d;
  logic                 busy_q, busy_d, done_q, done_d;
  logic                 vec_q, vec_d, zero_q, zero_d;
  logic [31:0]          base_q, base_d, afold;
  logic                 up;

  always_comb begin
    x_d = x_q; y_d = y_q; z_d = z_q; k_d = k_q;
    busy_d = busy_q; done_d = 1'b0;
    vec_d = vec_q; zero_d = zero_q; base_d = base_q;
    xe = CW'(x_i) <<< GuardBits;
    ye = CW'(y_i) <<< GuardBits;
    afold = ang_i + QuarterTurn;
    xs = x_q >>> k_q;
    ys = y_q >>> k_q;
    up = vec_q ? (y_q > 0) : (z_q < 0);
    if (start_i) begin
      busy_d = 1'b1;
      k_d    = '0;
      vec_d  = vec_i;
      zero_d = vec_i && (x_i == '0) && (y_i == '0);
      if (vec_i) begin
        z_d = '0;
        if (x_i < 0) begin
          x_d = -xe; y_d = -ye; base_d = HalfTurn;
        end else begin
          x_d = xe; y_d = ye; base_d = '0;
        end
      end else begin
        base_d = '0;
        if (afold[31]) begin
          x_d = -xe; y_d = -ye;
          z_d = 34'($signed(ang_i + HalfTurn));
        end else begin
          x_d = xe; y_d = ye;
          z_d = 34'($signed(ang_i));
        end
      end
    end else if (busy_q) begin
      if (up) begin
        x_d = x_q + ys; y_d = y_q - xs; z_d = z_q + $signed({2'b00, atan_at(k_q)});
      end else begin
        x_d = x_q - ys; y_d = y_q + xs; z_d = z_q - $signed({2'b00, atan_at(k_q)});
      end
      k_d = k_q + 5'd1;
      if (k_q == 5'(CordicSteps - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      k_q    <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      k_q    <= k_d;
    end
  end

  always_ff @(posedge clk_i) begin
    x_q    <= x_d;
    y_q    <= y_d;
    z_q    <= z_d;
    vec_q  <= vec_d;
    zero_q <= zero_d;
    base_q <= base_d;
  end

  assign done_o = done_q;
  assign x_o    = x_q;
  assign y_o    = y_q;
  assign ang_o  = zero_q ? 32'h0 : base_q + z_q[31:0];

endmodule

[src/ccd_ik_chain_solver.sv]
// ----------------------------------------------------------------------------
// ccd_ik_chain_solver
// 2D cyclic-coordinate-descent IK over a stored joint chain.
// ----------------------------------------------------------------------------
// channel   direction  beat contents
// s_axis    in         tdata: command, point_x, point_y (low bit up)
// m_axis    out        tdata: index, out_x, out_y; tlast marks end effector
// cfg       in         write of tolerance (index 0) or max_passes (index 1)
//
// Clear and append complete in the idle state. A solve runs distance checks,
// two vectoring CORDIC runs per joint and one rotation CORDIC run per rotated
// point (one shared CORDIC unit, one micro-rotation per cycle), then emits
// the points in turn. All chain points sit in one memory with a registered
// read, so every point access is a read, rotate, write back in turn. No input
// beat is taken while a solve or its output runs; output beats hold under
// m_axis_tready low. Reset clears the point count and loads config defaults.
// ----------------------------------------------------------------------------
module ccd_ik_chain_solver #(
  parameter int MAX_POINTS = 16,
  parameter int COORD_BITS = 24
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic                                   s_axis_tvalid,
  output logic                                   s_axis_tready,
  // command, point_x, point_y from bit 0 up, zero padded
  input  logic [((2*COORD_BITS+2+7)/8)*8-1:0]    s_axis_tdata,
  output logic                                   m_axis_tvalid,
  input  logic                                   m_axis_tready,
  // index, out_x, out_y from bit 0 up, zero padded
  output logic [((2*COORD_BITS+4+7)/8)*8-1:0]    m_axis_tdata,
  output logic                                   m_axis_tlast,
  input  logic                                   cfg_we_i,
  input  logic                                   cfg_addr_i,
  input  logic [15:0]                            cfg_wdata_i
);
  import ccd_pkg::*;

  localparam int CB   = COORD_BITS;
  localparam int DW   = CB + 1;
  localparam int CW   = CB + 8;
  localparam int PW   = CW + 25;
  localparam int AW   = $clog2(MAX_POINTS);
  localparam int NW   = $clog2(MAX_POINTS + 1);
  localparam int OW   = ((2*CB+4+7)/8)*8;
  localparam int SQW  = 2 * DW + 1;
  localparam int CMPW = (SQW > 32) ? SQW : 32;
  localparam logic [PW-1:0] Rnd = PW'(1) << (GuardBits + 23);

  typedef enum logic [16:0] {
    S_IDLE  = 17'h00001, S_DA   = 17'h00002, S_DB   = 17'h00004,
    S_DC    = 17'h00008, S_JNT  = 17'h00010, S_JLD  = 17'h00020,
    S_VEC1  = 17'h00040, S_VEC2 = 17'h00080, S_RRD  = 17'h00100,
    S_RLD   = 17'h00200, S_ROT  = 17'h00400, S_MULX = 17'h00800,
    S_MULY  = 17'h01000, S_WR   = 17'h02000, S_ERD  = 17'h04000,
    S_ELD   = 17'h08000, S_EOUT = 17'h10000
  } state_e;

  state_e state_q, state_d;

  logic [15:0]   tol_q;
  logic [7:0]    maxp_q, pass_q, pass_d;
  logic [NW-1:0] cnt_q, cnt_d;
  logic [AW-1:0] i_q, i_d, j_q, j_d, k_q, k_d, last_idx;
  logic          aj_q, aj_d;

  logic signed [CB-1:0] tx_q, ty_q, ex_q, ey_q, jx_q, jy_q, px_q, py_q;
  logic signed [CB-1:0] ex_d, ey_d;
  logic [31:0]          ang1_q, ang_q;
  logic signed [CW-1:0] rx_q, ry_q;
  logic signed [PW-1:0] prx_q, pry_q;
  logic [2*DW-1:0]      sqa_q, sqb_q;
  logic                 far_q, far;
  logic                 start_q, start_d;

  logic signed [CB-1:0] in_x, in_y, nx, ny;
  logic [1:0]           in_cmd;
  logic                 in_acc;

  logic                 ovalid_q, olast_q;
  logic [3:0]           oidx_q;
  logic [CB-1:0]        ox_q, oy_q;

  // memory port
  logic                 mem_we;
  logic [AW-1:0]        mem_waddr, mem_raddr;
  logic [2*CB-1:0]      mem_wdata, mem_rdata;

  // cordic port
  logic                 cor_vec, cor_done;
  logic signed [DW-1:0] cor_x, cor_y;
  logic signed [CW-1:0] cor_xo, cor_yo;
  logic [31:0]          cor_ang;

  // distance terms
  logic signed [DW-1:0] dx, dy;
  logic [DW-1:0]        adx, ady;
  logic [CMPW-1:0]      d2, t2;
  logic                 gt, lt;

  assign in_cmd = s_axis_tdata[1:0];
  assign in_x   = s_axis_tdata[CB+1:2];
  assign in_y   = s_axis_tdata[2*CB+1:CB+2];
  assign s_axis_tready = (state_q == S_IDLE);
  assign in_acc = s_axis_tvalid && s_axis_tready;
  assign last_idx = AW'(cnt_q - 1'b1);

  always_comb begin
    dx  = $signed({ex_q[CB-1], ex_q}) - $signed({tx_q[CB-1], tx_q});
    dy  = $signed({ey_q[CB-1], ey_q}) - $signed({ty_q[CB-1], ty_q});
    adx = dx[DW-1] ? DW'(-dx) : DW'(dx);
    ady = dy[DW-1] ? DW'(-dy) : DW'(dy);
    far = (DW > 31) && (((adx >> 31) != '0) || ((ady >> 31) != '0));
    d2  = CMPW'(sqa_q) + CMPW'(sqb_q);
    t2  = CMPW'({16'h0000, tol_q} * {16'h0000, tol_q});
    gt  = far_q || (d2 > t2);
    lt  = !far_q && (d2 < t2);
  end

  // round the gain-compensated product back to Q0, add joint back with saturation
  function automatic logic signed [CB-1:0] fin(input logic signed [PW-1:0] p,
                                               input logic signed [CB-1:0] j);
    logic [PW-1:0]        r;
    logic signed [CB+5:0] s;
    logic signed [CB-1:0] o;
    r = PW'(p) + Rnd;
    s = (CB+6)'($signed(r[PW-1:GuardBits+24])) + (CB+6)'(j);
    if (s[CB+5:CB-1] == '0 || s[CB+5:CB-1] == '1) o = s[CB-1:0];
    else if (s[CB+5]) o = {1'b1, {(CB-1){1'b0}}};
    else o = {1'b0, {(CB-1){1'b1}}};
    return o;
  endfunction

  assign nx = fin(prx_q, jx_q);
  assign ny = fin(pry_q, jy_q);

  always_comb begin
    cor_vec = 1'b1;
    cor_x   = $signed({tx_q[CB-1], tx_q}) - $signed({jx_q[CB-1], jx_q});
    cor_y   = $signed({ty_q[CB-1], ty_q}) - $signed({jy_q[CB-1], jy_q});
    if (state_q == S_VEC2) begin
      cor_x = $signed({ex_q[CB-1], ex_q}) - $signed({jx_q[CB-1], jx_q});
      cor_y = $signed({ey_q[CB-1], ey_q}) - $signed({jy_q[CB-1], jy_q});
    end else if (state_q == S_ROT) begin
      cor_vec = 1'b0;
      cor_x = $signed({px_q[CB-1], px_q}) - $signed({jx_q[CB-1], jx_q});
      cor_y = $signed({py_q[CB-1], py_q}) - $signed({jy_q[CB-1], jy_q});
    end
  end

  always_comb begin
    state_d = state_q;
    cnt_d = cnt_q; pass_d = pass_q; i_d = i_q; j_d = j_q; k_d = k_q;
    aj_d = aj_q; start_d = 1'b0; ex_d = ex_q; ey_d = ey_q;
    mem_we = 1'b0; mem_waddr = AW'(cnt_q); mem_wdata = {in_y, in_x};
    mem_raddr = k_q;
    case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          case (in_cmd)
            CMD_CLEAR: cnt_d = '0;
            CMD_APPEND: begin
              if (cnt_q < NW'(MAX_POINTS)) begin
                mem_we = 1'b1;
                ex_d = in_x; ey_d = in_y;
                cnt_d = cnt_q + 1'b1;
              end
            end
            CMD_SOLVE: begin
              if (cnt_q != '0) begin
                pass_d = '0; aj_d = 1'b0;
                state_d = S_DA;
              end
            end
            default: ;
          endcase
        end
      end
      S_DA: state_d = S_DB;
      S_DB: state_d = S_DC;
      S_DC: begin
        if (aj_q) begin
          state_d = lt ? S_ERD : S_JNT;
          k_d = '0;
        end else if (gt && pass_q < maxp_q) begin
          i_d = last_idx;
          state_d = S_JNT;
        end else begin
          k_d = '0;
          state_d = S_ERD;
        end
      end
      S_JNT: begin
        mem_raddr = i_q - 1'b1;
        if (i_q == '0) begin
          pass_d = pass_q + 8'd1;
          aj_d = 1'b0;
          state_d = S_DA;
        end else begin
          i_d = i_q - 1'b1;
          state_d = S_JLD;
        end
      end
      S_JLD: begin
        start_d = 1'b1;
        state_d = S_VEC1;
      end
      S_VEC1: begin
        if (cor_done) begin
          start_d = 1'b1;
          state_d = S_VEC2;
        end
      end
      S_VEC2: begin
        if (cor_done) begin
          j_d = i_q + 1'b1;
          state_d = S_RRD;
        end
      end
      S_RRD: begin
        mem_raddr = j_q;
        state_d = S_RLD;
      end
      S_RLD: begin
        start_d = 1'b1;
        state_d = S_ROT;
      end
      S_ROT: if (cor_done) state_d = S_MULX;
      S_MULX: state_d = S_MULY;
      S_MULY: state_d = S_WR;
      S_WR: begin
        mem_we = 1'b1;
        mem_waddr = j_q;
        mem_wdata = {ny, nx};
        if (j_q == last_idx) begin
          ex_d = nx; ey_d = ny;
          aj_d = 1'b1;
          state_d = S_DA;
        end else begin
          j_d = j_q + 1'b1;
          state_d = S_RRD;
        end
      end
      S_ERD: begin
        mem_raddr = k_q;
        state_d = S_ELD;
      end
      S_ELD: state_d = S_EOUT;
      S_EOUT: begin
        if (m_axis_tready) begin
          if (olast_q) state_d = S_IDLE;
          else begin
            k_d = k_q + 1'b1;
            state_d = S_ERD;
          end
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      cnt_q    <= '0;
      tol_q    <= 16'd26;
      maxp_q   <= 8'd10;
      start_q  <= 1'b0;
      ovalid_q <= 1'b0;
      aj_q     <= 1'b0;
      pass_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      start_q <= start_d;
      aj_q    <= aj_d;
      pass_q  <= pass_d;
      if (cfg_we_i) begin
        if (cfg_addr_i == REG_TOLERANCE) tol_q <= cfg_wdata_i;
        if (cfg_addr_i == REG_MAX_PASSES) maxp_q <= cfg_wdata_i[7:0];
      end
      if (state_q == S_ELD) ovalid_q <= 1'b1;
      else if (state_q == S_EOUT && m_axis_tready) ovalid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    i_q <= i_d; j_q <= j_d; k_q <= k_d;
    ex_q <= ex_d; ey_q <= ey_d;
    if (in_acc) begin
      tx_q <= in_x; ty_q <= in_y;
    end
    if (state_q == S_DA) begin
      sqa_q <= adx * adx;
      far_q <= far;
    end
    if (state_q == S_DB) sqb_q <= ady * ady;
    if (state_q == S_JLD) begin
      jx_q <= mem_rdata[CB-1:0];
      jy_q <= mem_rdata[2*CB-1:CB];
    end
    if (state_q == S_RLD) begin
      px_q <= mem_rdata[CB-1:0];
      py_q <= mem_rdata[2*CB-1:CB];
    end
    if (state_q == S_VEC1 && cor_done) ang1_q <= cor_ang;
    if (state_q == S_VEC2 && cor_done) ang_q <= ang1_q - cor_ang;
    if (state_q == S_ROT && cor_done) begin
      rx_q <= cor_xo; ry_q <= cor_yo;
    end
    if (state_q == S_MULX) prx_q <= PW'(rx_q) * PW'($signed({1'b0, InvGainQ24}));
    if (state_q == S_MULY) pry_q <= PW'(ry_q) * PW'($signed({1'b0, InvGainQ24}));
    if (state_q == S_ELD) begin
      ox_q    <= mem_rdata[CB-1:0];
      oy_q    <= mem_rdata[2*CB-1:CB];
      oidx_q  <= 4'(k_q);
      olast_q <= (k_q == last_idx);
    end
  end

  ccd_chain_mem #(.Depth(MAX_POINTS), .Width(2*CB)) u_mem (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  ccd_cordic #(.CoordBits(CB)) u_cordic (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (start_q),
    .vec_i   (cor_vec),
    .x_i     (cor_x),
    .y_i     (cor_y),
    .ang_i   (ang_q),
    .done_o  (cor_done),
    .x_o     (cor_xo),
    .y_o     (cor_yo),
    .ang_o   (cor_ang)
  );

  assign m_axis_tvalid = ovalid_q;
  assign m_axis_tlast  = olast_q;
  assign m_axis_tdata  = OW'({oy_q, ox_q, oidx_q});

endmodule
